[hw/rtl/thermistor_table_interpolator_assert.svh]
// Assertion macros for the checker file of the thermistor interpolator.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef THERMISTOR_TABLE_INTERPOLATOR_ASSERT_SVH
`define THERMISTOR_TABLE_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TTI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define TTI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/tti_pkg.sv]
// ----------------------------------------------------------------------------
// tti_pkg
// Breakpoint tables, widths and sequencer states for the thermistor
// table interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package tti_pkg;

  localparam int unsigned SAMPLE_W     = 12;
  localparam int unsigned TEMP_W       = 12;
  localparam int unsigned TABLE_POINTS = 53;
  localparam int unsigned IDX_W        = $clog2(TABLE_POINTS);
  localparam int unsigned PROD_W       = SAMPLE_W + TEMP_W;

  localparam logic [TEMP_W-1:0] TEMP_MIN = 12'd1500;
  localparam logic [TEMP_W-1:0] TEMP_MAX = 12'd4000;

  // Rising converter breakpoints.
  localparam logic [SAMPLE_W-1:0] BP_SAMPLE [TABLE_POINTS] = '{
    12'd0,    12'd183,  12'd231,  12'd278,  12'd326,  12'd375,  12'd426,
    12'd477,  12'd529,  12'd581,  12'd635,  12'd690,  12'd746,  12'd803,
    12'd862,  12'd921,  12'd981,  12'd1042, 12'd1105, 12'd1169, 12'd1233,
    12'd1300, 12'd1367, 12'd1435, 12'd1505, 12'd1576, 12'd1648, 12'd1722,
    12'd1797, 12'd1873, 12'd1950, 12'd2029, 12'd2109, 12'd2191, 12'd2274,
    12'd2359, 12'd2444, 12'd2532, 12'd2621, 12'd2711, 12'd2803, 12'd2896,
    12'd2991, 12'd3088, 12'd3186, 12'd3285, 12'd3386, 12'd3489, 12'd3594,
    12'd3700, 12'd3807, 12'd3916, 12'd4095
  };

  // Non-increasing temperatures in hundredths of a degree, one per breakpoint.
  localparam logic [TEMP_W-1:0] BP_TEMP [TABLE_POINTS] = '{
    12'd4000, 12'd4000, 12'd3950, 12'd3900, 12'd3850, 12'd3800, 12'd3750,
    12'd3700, 12'd3650, 12'd3600, 12'd3550, 12'd3500, 12'd3450, 12'd3400,
    12'd3350, 12'd3300, 12'd3250, 12'd3200, 12'd3150, 12'd3100, 12'd3050,
    12'd3000, 12'd2950, 12'd2900, 12'd2850, 12'd2800, 12'd2750, 12'd2700,
    12'd2650, 12'd2600, 12'd2550, 12'd2500, 12'd2450, 12'd2400, 12'd2350,
    12'd2300, 12'd2250, 12'd2200, 12'd2150, 12'd2100, 12'd2050, 12'd2000,
    12'd1950, 12'd1900, 12'd1850, 12'd1800, 12'd1750, 12'd1700, 12'd1650,
    12'd1600, 12'd1550, 12'd1550, 12'd1500
  };

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SEARCH = 5'b00010,
    ST_LOAD   = 5'b00100,
    ST_MUL    = 5'b01000,
    ST_DIV    = 5'b10000
  } tti_state_t;

endpackage

`default_nettype wire

[hw/rtl/thermistor_table_interpolator.sv]
// ----------------------------------------------------------------------------
// thermistor_table_interpolator
// Converts a 12-bit thermistor sample to hundredths of a degree by a
// sequential table search and linear interpolation with a serial divider.
//
//   channel   ports                          handshake
//   input     adc_sample                     start, taken when busy is low
//   result    temperature_centi              done, one-cycle strobe
//
// An item passes from idle through the search state, which walks the table
// one entry at a time and at most all 53 entries, then the load, multiply and
// divide states; the divide state covers the divider start, the quotient bits
// and the finishing step. A sample at or below the first breakpoint ends in
// the search state.
// busy is high from the accepting edge until the cycle in which done is shown.
// Reset is synchronous and returns the sequencer to idle with no result.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module thermistor_table_interpolator
  import tti_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [SAMPLE_W-1:0] adc_sample,
  output logic                     busy,
  output logic                     done,
  output logic [TEMP_W-1:0]        temperature_centi
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_POINTS - 1);

  tti_state_t          state;
  logic [SAMPLE_W-1:0] x;
  logic [IDX_W-1:0]    k;
  logic [SAMPLE_W-1:0] diff;
  logic [SAMPLE_W-1:0] span;
  logic [TEMP_W-1:0]   dt;
  logic [TEMP_W-1:0]   t_hi;
  logic [PROD_W-1:0]   prod;
  logic                div_start;
  logic                div_done;
  logic [PROD_W-1:0]   quotient;

  logic [SAMPLE_W-1:0] hi;
  logic [SAMPLE_W-1:0] lo;
  logic [TEMP_W-1:0]   tk;
  logic [TEMP_W-1:0]   tk_prev;
  logic [SAMPLE_W-1:0] x_clamp;

  always_comb begin
    hi      = BP_SAMPLE[k];
    lo      = BP_SAMPLE[k - IDX_W'(1)];
    tk      = BP_TEMP[k];
    tk_prev = BP_TEMP[k - IDX_W'(1)];
    x_clamp = (x > hi) ? hi : x;
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      done      <= 1'b0;
      div_start <= 1'b0;
    end else begin
      done      <= 1'b0;
      div_start <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (!(k < LAST_IDX && BP_SAMPLE[k] < x)) begin
            if (k == '0) begin
              state <= ST_IDLE;
              done  <= 1'b1;
            end else begin
              state <= ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          // A zero-width segment gives its upper temperature directly.
          if (hi <= lo) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end else begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state     <= ST_DIV;
          div_start <= 1'b1;
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        x <= adc_sample;
        k <= '0;
      end
      ST_SEARCH: begin
        if (k < LAST_IDX && BP_SAMPLE[k] < x) begin
          k <= k + IDX_W'(1);
        end else if (k == '0) begin
          temperature_centi <= BP_TEMP[0];
        end
      end
      ST_LOAD: begin
        diff              <= hi - x_clamp;
        span              <= hi - lo;
        dt                <= (tk_prev >= tk) ? (tk_prev - tk) : '0;
        t_hi              <= tk;
        temperature_centi <= tk;
      end
      ST_MUL: begin
        prod <= PROD_W'(diff) * PROD_W'(dt);
      end
      ST_DIV: begin
        if (div_done) begin
          temperature_centi <= t_hi + quotient[TEMP_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  tti_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (prod),
    .denom    (span),
    .done     (div_done),
    .quotient (quotient)
  );

endmodule

`default_nettype wire

[hw/rtl/tti_divider.sv]
// ----------------------------------------------------------------------------
// tti_divider
// Restoring divider, one quotient bit per cycle, for the interpolation
// fraction.
// ----------------------------------------------------------------------------
`default_nettype none

module tti_divider
  import tti_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [PROD_W-1:0] numer,
  input  wire logic [TEMP_W-1:0] denom,
  output logic                   done,
  output logic [PROD_W-1:0]      quotient
);

  localparam int unsigned CNT_W = $clog2(PROD_W + 1);

  logic [TEMP_W-1:0] den;
  logic [TEMP_W-1:0] rem;
  logic [CNT_W-1:0]  cnt;
  logic              active;
  logic [TEMP_W:0]   rem_shift;
  logic [TEMP_W+1:0] trial;

  assign rem_shift = {rem, quotient[PROD_W-1]};
  assign trial     = {1'b0, rem_shift} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CNT_W'(PROD_W);
      end else if (active) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // The partial remainder stays below the divisor, so it fits the divisor width.
  always_ff @(posedge clk) begin
    if (start) begin
      den      <= denom;
      rem      <= '0;
      quotient <= numer;
    end else if (active) begin
      if (!trial[TEMP_W+1]) begin
        rem      <= trial[TEMP_W-1:0];
        quotient <= {quotient[PROD_W-2:0], 1'b1};
      end else begin
        rem      <= rem_shift[TEMP_W-1:0];
        quotient <= {quotient[PROD_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tti_checker.sv]
// ----------------------------------------------------------------------------
// tti_checker
// Port-level checks on the handshake and result range of the thermistor
// table interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

`include "thermistor_table_interpolator_assert.svh"

module tti_checker
  import tti_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                done,
  input wire logic [TEMP_W-1:0]   temperature_centi
);

  // An accepted item keeps the block busy until its result appears.
  `TTI_ASSERT_NEXT(a_accept_busy, start && !busy, busy || done)
  // A result never follows an idle cycle directly.
  `TTI_ASSERT_NEXT(a_no_spurious_done, !busy, !done)
  // The block is released in the cycle its result is shown.
  `TTI_ASSERT_NOW(a_done_releases, done, !busy)
  // Every result lies inside the table's temperature range.
  `TTI_ASSERT_NOW(a_result_range, done,
                  temperature_centi >= TEMP_MIN && temperature_centi <= TEMP_MAX)

endmodule

bind thermistor_table_interpolator tti_checker u_tti_checker (
  .clk               (clk),
  .rst               (rst),
  .start             (start),
  .busy              (busy),
  .done              (done),
  .temperature_centi (temperature_centi)
);

`default_nettype wire

[dv/thermistor_table_interpolator_tb.sv]
// ----------------------------------------------------------------------------
// thermistor_table_interpolator_tb
// Drives converter samples through the start/busy handshake and checks every
// done strobe against a local table-interpolation model. Directed samples hit
// the range ends and the special regions of the table. Random samples cluster
// around breakpoints and span the full 12-bit range. Sender idle gaps are
// random, with back-to-back bursts and full drains.
// ----------------------------------------------------------------------------

module thermistor_table_interpolator_tb;
  import tti_pkg::*;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic [TEMP_W-1:0]   temp;
  } conversion_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic [SAMPLE_W-1:0] adc_sample;
  logic                busy;
  logic                done;
  logic [TEMP_W-1:0]   temperature_centi;

  conversion_t pending_temps[$];
  int unsigned mismatches;

  thermistor_table_interpolator dut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .adc_sample        (adc_sample),
    .busy              (busy),
    .done              (done),
    .temperature_centi (temperature_centi)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Table search for the first breakpoint not below the sample, then linear
  // interpolation toward the previous breakpoint with truncation.
  function automatic logic [TEMP_W-1:0] predict_temperature(input logic [SAMPLE_W-1:0] sample);
    int unsigned k;
    int unsigned x;
    int unsigned hi;
    int unsigned lo;
    int unsigned t_hi;
    int unsigned t_lo;
    int unsigned drop;
    int unsigned num;
    k = 0;
    x = sample;
    while (k < TABLE_POINTS - 1 && int'(BP_SAMPLE[k]) < x) k++;
    if (k == 0) return BP_TEMP[0];
    hi   = BP_SAMPLE[k];
    lo   = BP_SAMPLE[k-1];
    t_hi = BP_TEMP[k];
    t_lo = BP_TEMP[k-1];
    if (hi <= lo) return t_hi[TEMP_W-1:0];
    if (x > hi) x = hi;
    drop = (t_lo >= t_hi) ? t_lo - t_hi : 0;
    num  = (hi - x) * drop;
    return TEMP_W'(t_hi + num / (hi - lo));
  endfunction

  task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] sample,
                                 input logic [TEMP_W-1:0] exp_temp,
                                 input logic [TEMP_W-1:0] got_temp);
    $display("MISMATCH %s: sample %0d expected %0d got %0d at %0t",
             what, sample, exp_temp, got_temp, $realtime);
    mismatches++;
  endtask

  always @(posedge clk) begin
    conversion_t head;
    if (!rst && done) begin
      if (pending_temps.size() == 0) begin
        report_mismatch("unexpected result", '0, '0, temperature_centi);
      end else begin
        head = pending_temps.pop_front();
        if (temperature_centi !== head.temp)
          report_mismatch("temperature_centi", head.sample, head.temp, temperature_centi);
      end
    end
  end

  // One item: idle for the given number of cycles, then hold start until the
  // block takes the sample. The leading edge keeps start to one drive per step.
  task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input int unsigned gap);
    @(posedge clk);
    repeat (gap) @(posedge clk);
    start      <= 1'b1;
    adc_sample <= sample;
    do @(posedge clk); while (busy);
    pending_temps.push_back('{sample: sample, temp: predict_temperature(sample)});
    start <= 1'b0;
  endtask

  task automatic wait_for_results();
    while (pending_temps.size() != 0) @(posedge clk);
  endtask

  function automatic int unsigned draw_gap();
    // Roughly a quarter of the items go with no idle time at all.
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 19);
  endfunction

  function automatic logic [SAMPLE_W-1:0] near_breakpoint();
    int idx;
    int val;
    idx = $urandom_range(0, TABLE_POINTS - 1);
    val = int'(BP_SAMPLE[idx]) + int'($urandom_range(0, 6)) - 3;
    if (val < 0) val = 0;
    if (val > 4095) val = 4095;
    return val[SAMPLE_W-1:0];
  endfunction

  task automatic test_directed_edges();
    logic [SAMPLE_W-1:0] samples[$];
    samples = '{12'd0, 12'd4095, 12'd1, 12'd182, 12'd183, 12'd184, 12'd230, 12'd231,
                12'd232, 12'hAAA, 12'h555, 12'd2048, 12'd2047, 12'd3806, 12'd3807,
                12'd3860, 12'd3916, 12'd3917, 12'd4000, 12'd4094, 12'd1000, 12'd3000,
                12'd0, 12'd4095};
    foreach (samples[i]) send_sample(samples[i], draw_gap());
    wait_for_results();
  endtask

  task automatic test_breakpoint_neighbors();
    repeat (300) send_sample(near_breakpoint(), draw_gap());
  endtask

  task automatic test_uniform_samples();
    repeat (300) send_sample(SAMPLE_W'($urandom_range(0, 4095)), draw_gap());
  endtask

  // The low end walks few entries and the high end walks almost all of them,
  // so these bands give the shortest and longest conversions.
  task automatic test_range_bands();
    repeat (200) begin
      if ($urandom_range(0, 1) == 0)
        send_sample(SAMPLE_W'($urandom_range(0, 240)), draw_gap());
      else
        send_sample(SAMPLE_W'($urandom_range(3780, 4095)), draw_gap());
    end
  endtask

  task automatic test_back_to_back();
    repeat (4) begin
      repeat (25) send_sample(SAMPLE_W'($urandom_range(0, 4095)), 0);
    end
  endtask

  task automatic test_drain_and_resume();
    repeat (5) begin
      repeat (6) send_sample(near_breakpoint(), draw_gap());
      wait_for_results();
    end
  endtask

  initial begin
    mismatches = 0;
    rst        <= 1'b1;
    start      <= 1'b0;
    adc_sample <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed_edges();
    test_breakpoint_neighbors();
    test_drain_and_resume();
    test_uniform_samples();
    test_back_to_back();
    test_range_bands();

    wait_for_results();
    repeat (100) @(posedge clk);
    if (pending_temps.size() != 0) begin
      $display("MISMATCH %0d results never arrived", pending_temps.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("thermistor_table_interpolator_tb passed");
    end else begin
      $display("thermistor_table_interpolator_tb failed");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("TIMEOUT with %0d results outstanding", pending_temps.size());
    $display("thermistor_table_interpolator_tb failed");
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/tti_pkg.sv
hw/rtl/tti_divider.sv
hw/rtl/thermistor_table_interpolator.sv
hw/rtl/tti_checker.sv
dv/thermistor_table_interpolator_tb.sv
